// File: sv/bmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmx_pkg;

    // Trie geometry
    localparam int KEY_BITS   = 64;
    localparam int NODE_COUNT = 4096;

    // Port field widths
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int NODE_W  = $clog2(NODE_COUNT);          // child link / node index
    localparam int PTR_W   = $clog2(NODE_COUNT + 1);      // free pointer, may reach NODE_COUNT
    localparam int LEVEL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int WORD_W  = 2 * NODE_W;                  // {one_child, zero_child}

    // Item kind (s_tuser)
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Result status (m_tuser)
    localparam logic [STATUS_W-1:0] STATUS_QUERY    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

endpackage

`default_nettype wire

// File: sv/binary_trie_max_xor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Dir | Handshake         | Payload
// -----------+-----+-------------------+------------------------------------------
// s_ (items) | in  | s_tvalid/s_tready | s_tdata: key_value[63:0]; s_tuser: kind
// m_ (result)| out | m_tvalid/m_tready | m_tdata: max_xor[63:0];   m_tuser: status
//
// One item at a time. A transfer on s_ starts a walk of KEY_BITS levels through the
// node RAM, one level per cycle (the registered RAM read feeds the next address). The
// result is offered with s_tready returning at the same time; a query on an empty trie
// ends its walk at the root, and a refused insert skips the walk.
// Reset needs no clearing pass: the root entry reads as empty until first written.
// A stalled m_ holds the result; the next item is taken and its result waits in ST_HOLD.

module binary_trie_max_xor (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input items
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [bmx_pkg::DATA_W-1:0]   s_tdata,   // [63:0] key_value
    input  wire logic                         s_tuser,   // [0] kind
    // results
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [bmx_pkg::DATA_W-1:0]   m_tdata,   // [63:0] max_xor
    output logic      [bmx_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,   // read-driven descent, one level per cycle
        ST_ALLOC = 4'b0100,   // insert tail: new nodes only, no reads
        ST_HOLD  = 4'b1000    // result ready, waiting for the output register
    } state_t;

    state_t                            state_reg, state_next;
    logic                              kind_reg, kind_next;
    logic [bmx_pkg::KEY_BITS-1:0]      key_reg, key_next;
    logic [bmx_pkg::KEY_BITS-1:0]      res_reg, res_next;
    logic [bmx_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [bmx_pkg::LEVEL_W-1:0]       level_reg, level_next;
    logic [bmx_pkg::NODE_W-1:0]        node_reg, node_next;     // node whose word is on rd_data
    logic [bmx_pkg::PTR_W-1:0]         free_reg, free_next;
    logic                              root_valid_reg, root_valid_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [bmx_pkg::DATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [bmx_pkg::STATUS_W-1:0]      m_tuser_reg, m_tuser_next;

    // node RAM: {one_child, zero_child}, a link of 0 means no child
    logic                              wr_en;
    logic [bmx_pkg::NODE_W-1:0]        wr_addr;
    logic [bmx_pkg::WORD_W-1:0]        wr_data;
    logic [bmx_pkg::NODE_W-1:0]        rd_addr;
    logic [bmx_pkg::WORD_W-1:0]        rd_data;

    bmx_ram #(
        .WIDTH (bmx_pkg::WORD_W),
        .DEPTH (bmx_pkg::NODE_COUNT)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [bmx_pkg::WORD_W-1:0] node_word;
    logic [bmx_pkg::NODE_W-1:0] zero_c, one_c, same_c, opp_c, new_node;
    logic                       cur_bit, last_level, out_free, table_full;

    // root reads as empty until its first write after reset
    assign node_word  = (node_reg == '0 && !root_valid_reg) ? '0 : rd_data;
    assign zero_c     = node_word[bmx_pkg::NODE_W-1:0];
    assign one_c      = node_word[bmx_pkg::WORD_W-1:bmx_pkg::NODE_W];
    assign cur_bit    = key_reg[level_reg];
    assign same_c     = cur_bit ? one_c : zero_c;
    assign opp_c      = cur_bit ? zero_c : one_c;
    assign last_level = (level_reg == '0);
    assign new_node   = free_reg[bmx_pkg::NODE_W-1:0];
    assign out_free   = !m_tvalid_reg || m_tready;
    // fewer than KEY_BITS free nodes left
    assign table_full = free_reg > bmx_pkg::PTR_W'(bmx_pkg::NODE_COUNT - bmx_pkg::KEY_BITS);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        level_next      = level_reg;
        node_next       = node_reg;
        free_next       = free_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_data         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    key_next   = s_tdata[bmx_pkg::KEY_BITS-1:0];
                    res_next   = '0;
                    level_next = bmx_pkg::LEVEL_W'(bmx_pkg::KEY_BITS - 1);
                    node_next  = '0;   // rd_addr already points at the root
                    if (s_tuser == bmx_pkg::KIND_QUERY) begin
                        status_next = bmx_pkg::STATUS_QUERY;
                        state_next  = ST_WALK;
                    end else if (table_full) begin
                        status_next = bmx_pkg::STATUS_FULL;
                        state_next  = ST_HOLD;
                    end else begin
                        status_next = bmx_pkg::STATUS_INSERTED;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (kind_reg == bmx_pkg::KIND_QUERY) begin
                    if (opp_c != '0 || same_c != '0) begin
                        if (opp_c != '0) begin
                            res_next[level_reg] = 1'b1;
                            node_next           = opp_c;
                        end else begin
                            node_next = same_c;
                        end
                        rd_addr = node_next;
                        if (last_level) begin
                            state_next = ST_HOLD;
                        end else begin
                            level_next = level_reg - bmx_pkg::LEVEL_W'(1);
                        end
                    end else begin
                        state_next = ST_HOLD;   // dead end: answer so far stands
                    end
                end else if (same_c != '0) begin
                    node_next = same_c;
                    rd_addr   = same_c;
                    if (last_level) begin
                        state_next = ST_HOLD;
                    end else begin
                        level_next = level_reg - bmx_pkg::LEVEL_W'(1);
                    end
                end else begin
                    // first missing link: patch parent, keep its other child
                    wr_en     = 1'b1;
                    wr_data   = cur_bit ? {new_node, zero_c} : {one_c, new_node};
                    free_next = free_reg + bmx_pkg::PTR_W'(1);
                    node_next = new_node;
                    if (last_level) begin
                        state_next = ST_HOLD;
                    end else begin
                        level_next = level_reg - bmx_pkg::LEVEL_W'(1);
                        state_next = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC: begin
                // fresh node: the write also clears its other child
                wr_en     = 1'b1;
                wr_data   = cur_bit ? {new_node, bmx_pkg::NODE_W'(0)}
                                    : {bmx_pkg::NODE_W'(0), new_node};
                free_next = free_reg + bmx_pkg::PTR_W'(1);
                node_next = new_node;
                if (last_level) begin
                    state_next = ST_HOLD;
                end else begin
                    level_next = level_reg - bmx_pkg::LEVEL_W'(1);
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = bmx_pkg::DATA_W'(res_reg);
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        root_valid_next = root_valid_reg || (wr_en && wr_addr == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_reg       <= bmx_pkg::PTR_W'(1);
            root_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_reg       <= free_next;
            root_valid_reg <= root_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        level_reg   <= level_next;
        node_reg    <= node_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

// File: sv/bmx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/bmx_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bmx_props (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [bmx_pkg::DATA_W-1:0]   m_tdata,
    input wire logic [bmx_pkg::STATUS_W-1:0] m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // only defined status codes leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == bmx_pkg::STATUS_QUERY || m_tuser == bmx_pkg::STATUS_INSERTED
                      || m_tuser == bmx_pkg::STATUS_FULL))
        else $error("undefined status");

    // inserts carry a zero answer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bmx_pkg::STATUS_QUERY |-> m_tdata == '0)
        else $error("insert result with nonzero data");

    // one item in flight: busy right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind binary_trie_max_xor bmx_props u_bmx_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: sim/bmx_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the trie and checks every result transfer
// against the oldest expected answer.
module bmx_checker
    import bmx_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [DATA_W-1:0]   s_tdata,   // [63:0] key_value
    input  wire logic                s_tuser,   // [0] kind
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [DATA_W-1:0]   m_tdata,   // [63:0] max_xor
    input  wire logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output int                       errors,
    output int                       pending,
    output int                       stored,
    output int                       refused,
    output int                       queried
);

    localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - KEY_BITS);

    typedef struct packed {
        logic [DATA_W-1:0]   max_xor;
        logic [STATUS_W-1:0] status;
    } answer_t;

    answer_t           answers_due[$];
    logic [NODE_W-1:0] zero_link [NODE_COUNT];
    logic [NODE_W-1:0] one_link  [NODE_COUNT];
    logic [PTR_W-1:0]  free_ptr;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Adds the key's path; refused when fewer than KEY_BITS nodes are left.
    function automatic logic [STATUS_W-1:0] trie_insert(input logic [DATA_W-1:0] key);
        int                node;
        int                idx;
        logic [NODE_W-1:0] child;
        if (NODE_COUNT - int'(free_ptr) < KEY_BITS)
            return STATUS_FULL;
        node = 0;
        for (idx = KEY_BITS - 1; idx >= 0; idx--) begin
            child = key[idx] ? one_link[node] : zero_link[node];
            if (child == '0) begin
                child            = free_ptr[NODE_W-1:0];
                zero_link[child] = '0;
                one_link[child]  = '0;
                free_ptr         = free_ptr + 1'b1;
                if (key[idx])
                    one_link[node] = child;
                else
                    zero_link[node] = child;
            end
            node = child;
        end
        return STATUS_INSERTED;
    endfunction

    // Greedy walk: prefer the branch opposite to each query bit.
    function automatic logic [DATA_W-1:0] best_xor(input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] acc;
        int                node;
        int                idx;
        logic [NODE_W-1:0] other;
        logic [NODE_W-1:0] same;
        acc  = '0;
        node = 0;
        for (idx = KEY_BITS - 1; idx >= 0; idx--) begin
            other = q[idx] ? zero_link[node] : one_link[node];
            if (other != '0) begin
                acc[idx] = 1'b1;
                node     = other;
            end else begin
                same = q[idx] ? one_link[node] : zero_link[node];
                if (same == '0)
                    return acc;
                node = same;
            end
        end
        return acc;
    endfunction

    always @(posedge aclk) begin
        answer_t           due;
        answer_t           head;
        logic [DATA_W-1:0] key;
        if (!aresetn) begin
            answers_due.delete();
            for (int n = 0; n < NODE_COUNT; n++) begin
                zero_link[n] = '0;
                one_link[n]  = '0;
            end
            free_ptr = 1;
            errors   = 0;
            stored   = 0;
            refused  = 0;
            queried  = 0;
            pending <= 0;
        end else begin
            // result side first: it always belongs to an item taken earlier
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result max_xor=%h status=%0d",
                                              m_tdata, m_tuser));
                end else begin
                    head = answers_due.pop_front();
                    if (m_tdata !== head.max_xor)
                        report_mismatch($sformatf("max_xor %h, expected %h",
                                                  m_tdata, head.max_xor));
                    if (m_tuser !== head.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, head.status));
                end
            end
            if (s_tvalid && s_tready) begin
                key = s_tdata & KEY_MASK;
                if (s_tuser == KIND_INSERT) begin
                    due.max_xor = '0;
                    due.status  = trie_insert(key);
                    if (due.status == STATUS_FULL)
                        refused++;
                    else
                        stored++;
                end else begin
                    due.max_xor = best_xor(key);
                    due.status  = STATUS_QUERY;
                    queried++;
                end
                answers_due.push_back(due);
            end
            pending <= answers_due.size();
        end
    end

endmodule

// File: sim/tb_binary_trie_max_xor.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all checking sits in bmx_checker.
module tb_binary_trie_max_xor;
    import bmx_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * (KEY_BITS + 2) + 16;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic                s_tuser  = KIND_INSERT;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int errors;
    int pending;
    int stored;
    int refused;
    int queried;

    int   cycles        = 0;
    int   send_idle_pct = 19;
    int   recv_idle_pct = 54;
    logic hold_request  = 1'b0;
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;

    logic [DATA_W-1:0] keys_offered[$];
    logic [DATA_W-1:0] cluster_base[4];

    binary_trie_max_xor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bmx_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .stored   (stored),
        .refused  (refused),
        .queried  (queried)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("binary_trie_max_xor verification failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            hold_taken <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One transfer on s_; valid never drops once raised until the item is taken.
    task automatic send_item(input logic kind, input logic [DATA_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_INSERT)
            keys_offered.push_back(key);
    endtask

    initial begin
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty trie, extreme keys, duplicates, alternating patterns
        send_item(KIND_QUERY,  64'h0);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 64'h0);
        send_item(KIND_QUERY,  64'h0);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 64'h0);
        send_item(KIND_QUERY,  64'h0);
        send_item(KIND_QUERY,  64'h8000_0000_0000_0000);
        send_item(KIND_INSERT, 64'h8000_0000_0000_0000);
        send_item(KIND_INSERT, 64'h0000_0000_0000_0001);
        send_item(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_INSERT, 64'h5555_5555_5555_5555);
        send_item(KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_QUERY,  64'h5555_5555_5555_5555);
        send_item(KIND_QUERY,  64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_QUERY,  64'hFFFF_FFFF_0000_0000);
        send_item(KIND_QUERY,  64'h0000_0000_0000_0001);

        for (int b = 0; b < 4; b++)
            cluster_base[b] = {$urandom, $urandom};

        // random: mostly clustered keys so many inserts succeed before the table fills,
        // queries close to stored keys so walks go deep
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct =  54;
                recv_idle_pct <= 19;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct =  0;
                recv_idle_pct <= 0;
                hold_request  <= 1'b1;
            end
            pick = keys_offered[$urandom_range(keys_offered.size() - 1)];
            if ($urandom_range(99) < 45) begin
                case ($urandom_range(9))
                    0:             key = {$urandom, $urandom};
                    1, 2, 3, 4, 5, 6:
                        key = {cluster_base[$urandom_range(3)][DATA_W-1:12], 12'($urandom)};
                    default:       key = pick;
                endcase
                send_item(KIND_INSERT, key);
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3:    key = {$urandom, $urandom};
                    4, 5, 6:       key = pick ^ (64'h1 << $urandom_range(DATA_W - 1));
                    7:             key = pick;
                    default:       key = ~pick;
                endcase
                send_item(KIND_QUERY, key);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items: %0d keys stored, %0d inserts refused on a full table, %0d queries",
                 stored + refused + queried, stored, refused, queried);
        $display("idle mixes 19/54, 54/19 and none, with one %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("binary_trie_max_xor verification clean");
        end else begin
            $display("binary_trie_max_xor verification failed");
        end
        $finish;
    end

endmodule
